// File: rtl/sdr_pkg.sv
`default_nettype none

package sdr_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);
  localparam int unsigned ValueW     = 32;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [ValueW-1:0] value_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  // Port of the table memory, driven by the controller.
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    value_t wdata;
    addr_t  raddr;
  } ram_req_t;

  // One result, as it leaves the controller.
  typedef struct packed {
    value_t value;
    logic   unique_res;
    logic   last;
    logic   overflow;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/stream_duplicate_remover.sv
// A result is registered after the controller compares its request against n table entries,
// where n is at most the values held for the set (0 to 64).
// Requests are taken one at a time, only while idle; the single read port
// of the value table, scanned one entry per cycle, sets the pace.
// Reset: the fill count and all handshake state clear; table contents stay
// undefined and need no clearing pass, since only filled entries are read.
`default_nettype none

module stream_duplicate_remover (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic        s_axis_tlast_i,   // last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] value_out
  output logic [1:0]       m_axis_tuser_o,   // [0] unique_res, [1] overflow
  output logic             m_axis_tlast_o    // last_out
);
  import sdr_pkg::*;

  ram_req_t ram_req;
  value_t   ram_rdata;
  logic     res_valid;
  res_t     res;
  logic     out_free;

  res_t     out_q;
  logic     out_valid_q;

  // The output register parts the two sides: the controller may finish the
  // next request as soon as the held result is taken in the same cycle.
  assign out_free = !out_valid_q || m_axis_tready_i;

  // The controller accepts a request, scans the filled table entries in order
  // through the memory's registered read port, then, if the value was not found and the
  // table is not full, writes it at the fill position. The write lands in the finish
  // cycle, whose read data is never used.
  sdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_value_i  (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sdr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.value;
  assign m_axis_tuser_o  = {out_q.overflow, out_q.unique_res};
  assign m_axis_tlast_o  = out_q.last;

endmodule

`default_nettype wire

// File: rtl/sdr_ram.sv
`default_nettype none

module sdr_ram (
  input  wire logic              clk_i,
  input  wire sdr_pkg::ram_req_t req_i,
  output logic [sdr_pkg::ValueW-1:0] rdata_o
);
  import sdr_pkg::*;

  value_t mem [TableDepth];
  value_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/sdr_ctrl.sv
`default_nettype none

module sdr_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [sdr_pkg::ValueW-1:0] in_value_i,
  input  wire logic                      in_last_i,
  output sdr_pkg::ram_req_t              ram_req_o,
  input  wire logic [sdr_pkg::ValueW-1:0] ram_rdata_i,
  input  wire logic                      out_free_i,
  output logic                           res_valid_o,
  output sdr_pkg::res_t                  res_o
);
  import sdr_pkg::*;

  localparam count_t Full = CountW'(TableDepth);

  state_e state_q, state_d;
  count_t count_q, count_d;
  addr_t  cmp_idx_q, cmp_idx_d;
  logic   found_q, found_d;
  value_t value_q;
  logic   last_q;

  logic   hit;
  logic   scan_end;
  logic   accept;
  logic   fire;
  logic   store;

  // Read data in the scan state belongs to entry cmp_idx_q.
  assign hit      = (ram_rdata_i == value_q);
  assign scan_end = ({1'b0, cmp_idx_q} + count_t'(1)) == count_q;
  assign accept   = in_valid_i && in_ready_o;
  assign fire     = res_valid_o;
  assign store    = !found_q && (count_q < Full);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = (count_q == '0) ? StFinish : StScan;
        end
      end
      StScan: begin
        if (hit || scan_end) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    res_valid_o     = 1'b0;
    ram_req_o.raddr = cmp_idx_q + addr_t'(1);
    unique case (state_q)
      StIdle: begin
        in_ready_o      = 1'b1;
        ram_req_o.raddr = '0;
      end
      StScan: begin
      end
      StFinish: begin
        res_valid_o = out_free_i;
      end
      default: begin
      end
    endcase
    ram_req_o.we    = fire && store;
    ram_req_o.waddr = count_q[AddrW-1:0];
    ram_req_o.wdata = value_q;
  end

  always_comb begin
    count_d   = count_q;
    cmp_idx_d = cmp_idx_q;
    found_d   = found_q;
    if (accept) begin
      cmp_idx_d = '0;
      found_d   = 1'b0;
    end
    if (state_q == StScan) begin
      if (hit) begin
        found_d = 1'b1;
      end else begin
        cmp_idx_d = cmp_idx_q + addr_t'(1);
      end
    end
    if (fire) begin
      if (last_q) begin
        count_d = '0;
      end else if (store) begin
        count_d = count_q + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      cmp_idx_q <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_idx_q <= cmp_idx_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= in_value_i;
      last_q  <= in_last_i;
    end
  end

  assign res_o.value      = value_q;
  assign res_o.unique_res = store;
  assign res_o.last       = last_q;
  assign res_o.overflow   = !found_q && !(count_q < Full);

endmodule

`default_nettype wire
